// File: hdl/ckab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckab_pkg: shared types and constants
// Types, request codes and the key helper for the chroma keyed alpha blend.
// ----------------------------------------------------------------------------
package ckab_pkg;

    localparam int BYTE_W    = 8;
    localparam int PROD_W    = 2 * BYTE_W;
    localparam int DIV_STEPS = BYTE_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [PROD_W-1:0] t_prod;
    typedef logic [CNT_W-1:0]  t_cnt;

    localparam logic REQ_MEASURE = 1'b0;
    localparam logic REQ_BLEND   = 1'b1;

    localparam t_byte KEY_NIB_MASK = 8'hF0;
    localparam t_byte FULL_SCALE   = 8'd255;
    localparam t_byte KEY_MIN_INIT = 8'd255;
    localparam t_byte KEY_MAX_INIT = 8'd0;

    // key update request to the statistics unit
    typedef struct packed {
        logic  en;
        logic  first;
        t_byte key;
    } t_key_upd;

    // measured key range
    typedef struct packed {
        t_byte kmin;
        t_byte kmax;
    } t_key_range;

    // high nibble of channel 1 over high nibble of channel 2
    function automatic t_byte make_key(input t_byte c1, input t_byte c2);
        t_byte hi;
        t_byte lo;
        hi = c1 & KEY_NIB_MASK;
        lo = (c2 & KEY_NIB_MASK) >> 4;
        return hi | lo;
    endfunction

endpackage

// File: hdl/ckab_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckab_if: stream channels
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface ckab_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic       first_pixel;
    logic [7:0] fg_ch0;
    logic [7:0] fg_ch1;
    logic [7:0] fg_ch2;
    logic [7:0] bg_ch0;
    logic [7:0] bg_ch1;
    logic [7:0] bg_ch2;

    modport source (
        output valid, req_type, first_pixel,
        output fg_ch0, fg_ch1, fg_ch2, bg_ch0, bg_ch1, bg_ch2,
        input  ready
    );
    modport sink (
        input  valid, req_type, first_pixel,
        input  fg_ch0, fg_ch1, fg_ch2, bg_ch0, bg_ch1, bg_ch2,
        output ready
    );
endinterface

interface ckab_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_ch0;
    logic [7:0] out_ch1;
    logic [7:0] out_ch2;
    logic [7:0] out_alpha;
    logic       flat_key;

    modport source (
        output valid, out_ch0, out_ch1, out_ch2, out_alpha, flat_key,
        input  ready
    );
    modport sink (
        input  valid, out_ch0, out_ch1, out_ch2, out_alpha, flat_key,
        output ready
    );
endinterface

// File: hdl/ckab_key_stats.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckab_key_stats: key range tracker
// Running minimum and maximum of the key, restarted by the first pixel flag.
// ----------------------------------------------------------------------------
module ckab_key_stats (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ckab_pkg::t_key_upd   i_upd,
    output ckab_pkg::t_key_range o_range
);
    import ckab_pkg::*;

    t_byte r_min;
    t_byte r_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= KEY_MIN_INIT;
            r_max <= KEY_MAX_INIT;
        end else if (i_upd.en) begin
            if (i_upd.first) begin
                r_min <= i_upd.key;
                r_max <= i_upd.key;
            end else begin
                if (i_upd.key < r_min) begin
                    r_min <= i_upd.key;
                end
                if (i_upd.key > r_max) begin
                    r_max <= i_upd.key;
                end
            end
        end
    end

    assign o_range.kmin = r_min;
    assign o_range.kmax = r_max;

endmodule

// File: hdl/ckab_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckab_div: bit-serial restoring divider
// One quotient bit per step; quotient must fit in one byte.
// ----------------------------------------------------------------------------
module ckab_div (
    input  logic            i_clk,
    input  logic            i_load,
    input  logic            i_step,
    input  ckab_pkg::t_prod i_num,
    input  ckab_pkg::t_byte i_den,
    output ckab_pkg::t_byte o_quo
);
    import ckab_pkg::*;

    t_byte               r_rem;
    t_byte               r_sh;    // numerator low bits out, quotient bits in
    t_byte               r_den;
    logic [BYTE_W:0]     rem_sh;
    logic [BYTE_W:0]     diff;
    logic                ge;

    assign rem_sh = {r_rem, r_sh[BYTE_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign diff   = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= i_num[PROD_W-1:BYTE_W];
            r_sh  <= i_num[BYTE_W-1:0];
            r_den <= i_den;
        end else if (i_step) begin
            r_rem <= ge ? diff[BYTE_W-1:0] : rem_sh[BYTE_W-1:0];
            r_sh  <= {r_sh[BYTE_W-2:0], ge};
        end
    end

    assign o_quo = r_sh;

endmodule

// File: hdl/chroma_keyed_alpha_blend.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chroma_keyed_alpha_blend: keyed alpha blend with min/max normalized key
// Measure pass tracks the key range, blend pass mixes foreground/background.
// ----------------------------------------------------------------------------
// usage:
//   i_in  carries request beats: req_type 0 measures the key of the
//         foreground pixel (first_pixel restarts min/max), req_type 1
//         blends one foreground/background pair
//   o_out carries one result beat per blend request, none per measure
// timing:
//   a measure beat is absorbed in the cycle it is accepted; the block is
//   ready again on the next cycle
//   a blend beat has its operands captured at accept, its 8x8 products
//   loaded into four bit-serial dividers (one quotient bit each per
//   cycle), then the result lands in the output register; input ready
//   returns as the result is loaded, so no new request is taken while
//   a blend beat is in flight
// reset:
//   synchronous active low; key min goes to 255, max to 0, output empty
// stall:
//   the output register holds a finished result while the sink stalls;
//   the next request is still taken and runs until its own result needs
//   the output register, where it waits
// ----------------------------------------------------------------------------
module chroma_keyed_alpha_blend (
    input  logic  i_clk,
    input  logic  i_rst_n,
    ckab_in_if.sink    i_in,
    ckab_out_if.source o_out
);
    import ckab_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_OUT
    } t_state;

    t_state     r_state;
    t_cnt       r_cnt;

    // operands captured at accept
    t_byte      r_wf;
    t_byte      r_wb;
    t_byte      r_d;
    logic       r_flat;
    t_byte      r_fg0, r_fg1, r_fg2;
    t_byte      r_bg0, r_bg1, r_bg2;

    // output register
    logic       r_ovalid;
    t_byte      r_och0, r_och1, r_och2, r_oalpha;
    logic       r_oflat;

    t_key_upd   key_upd;
    t_key_range key_rng;
    t_byte      key;
    t_byte      key_c;
    logic       accept;
    logic       out_free;

    t_prod      num0, num1, num2, num_a;
    t_byte      quo0, quo1, quo2, quo_a;
    logic       div_load;
    logic       div_step;

    assign key      = make_key(i_in.fg_ch1, i_in.fg_ch2);
    assign i_in.ready = (r_state == S_IDLE);
    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_out.ready;

    // measure beats update the range at accept
    assign key_upd.en    = accept && (i_in.req_type == REQ_MEASURE);
    assign key_upd.first = i_in.first_pixel;
    assign key_upd.key   = key;

    ckab_key_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_upd   (key_upd),
        .o_range (key_rng)
    );

    // saturate the key into the measured range
    always_comb begin
        key_c = key;
        if (key < key_rng.kmin) begin
            key_c = key_rng.kmin;
        end
        if (key > key_rng.kmax) begin
            key_c = key_rng.kmax;
        end
    end

    // weighted sums; each stays below d*256 so the quotient fits a byte
    assign num0  = PROD_W'(r_wf * r_fg0) + PROD_W'(r_wb * r_bg0);
    assign num1  = PROD_W'(r_wf * r_fg1) + PROD_W'(r_wb * r_bg1);
    assign num2  = PROD_W'(r_wf * r_fg2) + PROD_W'(r_wb * r_bg2);
    assign num_a = PROD_W'(r_wf * FULL_SCALE);

    assign div_load = (r_state == S_MUL);
    assign div_step = (r_state == S_DIV);

    ckab_div u_div0 (.i_clk(i_clk), .i_load(div_load), .i_step(div_step),
                     .i_num(num0), .i_den(r_d), .o_quo(quo0));
    ckab_div u_div1 (.i_clk(i_clk), .i_load(div_load), .i_step(div_step),
                     .i_num(num1), .i_den(r_d), .o_quo(quo1));
    ckab_div u_div2 (.i_clk(i_clk), .i_load(div_load), .i_step(div_step),
                     .i_num(num2), .i_den(r_d), .o_quo(quo2));
    ckab_div u_diva (.i_clk(i_clk), .i_load(div_load), .i_step(div_step),
                     .i_num(num_a), .i_den(r_d), .o_quo(quo_a));

    // operand capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_wf   <= key_c - key_rng.kmin;
            r_wb   <= key_rng.kmax - key_c;
            r_d    <= key_rng.kmax - key_rng.kmin;
            r_flat <= key_rng.kmax <= key_rng.kmin;
            r_fg0  <= i_in.fg_ch0;
            r_fg1  <= i_in.fg_ch1;
            r_fg2  <= i_in.fg_ch2;
            r_bg0  <= i_in.bg_ch0;
            r_bg1  <= i_in.bg_ch1;
            r_bg2  <= i_in.bg_ch2;
        end
    end

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // a new result loading in the same cycle keeps valid high
            if (r_ovalid && o_out.ready && !((r_state == S_OUT) && out_free)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_in.req_type == REQ_BLEND)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        if (r_flat) begin
                            r_och0   <= r_bg0;
                            r_och1   <= r_bg1;
                            r_och2   <= r_bg2;
                            r_oalpha <= '0;
                        end else begin
                            r_och0   <= quo0;
                            r_och1   <= quo1;
                            r_och2   <= quo2;
                            r_oalpha <= quo_a;
                        end
                        r_oflat <= r_flat;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.out_ch0   = r_och0;
    assign o_out.out_ch1   = r_och1;
    assign o_out.out_ch2   = r_och2;
    assign o_out.out_alpha = r_oalpha;
    assign o_out.flat_key  = r_oflat;

endmodule
